>>> rtl/core/prom_pkg.sv
// Package for the periodic release overrun monitor.
// Holds task counts, field widths, register indexes and the result beat type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prom_pkg;

	// task slots kept in the register file, and tasks walked per tick
	localparam int SLOT_COUNT = 4;
	localparam int TASK_COUNT = 4;
	localparam int TASK_W     = 2;

	localparam int PERIOD_W = 16;
	localparam int OVR_W    = 8;
	localparam int OVC_W    = 16;
	localparam int RESP_W   = 24;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 72;
	localparam int CFG_IDX_W  = 8;

	localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(TASK_COUNT - 1);

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BASE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_BASE  = CFG_IDX_W'(SLOT_COUNT);
	localparam logic [CFG_IDX_W-1:0] REG_END         = CFG_IDX_W'(2 * SLOT_COUNT);

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);
	localparam logic [PERIOD_W-1:0] PHASE_RESET  = PERIOD_W'(1);

	localparam logic [OVR_W-1:0] OVR_MAX = '1;
	localparam logic [OVC_W-1:0] OVC_MAX = '1;

	// one result beat
	typedef struct packed {
		logic [TASK_W-1:0] task_index;
		logic              job_finished;
		logic [RESP_W-1:0] response_ticks;
		logic              release_now;
		logic              overrun_now;
		logic [OVC_W-1:0]  overrun_total;
		logic [RESP_W-1:0] worst_response;
		logic              last_of_tick;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/periodic_release_overrun_monitor.sv
// Top level of the periodic release overrun monitor.
// Walks the tasks of one tick, one task per cycle unless the output stalls; uses prom_pkg.
// Periodic release monitor, one input beat per scheduler tick.
// Input channel (s_*): a tick beat carries the idle and unavailable masks.
// Output channel (m_*): four result beats per tick, task 0 first; tuser is the
//   task index and tlast marks the beat of the final task.
// Config channel (cfg_*): always ready; index 0..3 writes a task period,
//   4..7 a task phase (which also reloads that task's countdown), others are
//   dropped. Write only while no tick is in flight.
// Timing: a tick is captured into an input register, then one task per cycle
//   is updated and written into the output register. Throughput is one result
//   per cycle while the output is not stalled, set by the one-task-per-cycle
//   update path (one 16x9 multiply, subtract and compare). The next tick is
//   taken in the cycle the last task of the current one moves to the output
//   register.
// Reset: countdowns load 1, periods 100, phases 1, all counters clear.
// Stall: when m_tready is low while a result is held, the output register
//   holds and the task walk pauses; a captured tick waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module periodic_release_overrun_monitor
	import prom_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// tick channel
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [3:0] idle_mask, [7:4] unavailable_mask
	// result channel
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // job_finished, response_ticks[24],
	                                              // release_now, overrun_now,
	                                              // overrun_total[16], worst_response[24], zeros
	output logic [TASK_W-1:0]          m_tuser,   // task_index
	output logic                       m_tlast,   // last_of_tick
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [PERIOD_W-1:0]   cfg_data
);

	// configuration and per-task state
	logic [PERIOD_W-1:0] period_q    [SLOT_COUNT];
	logic [PERIOD_W-1:0] countdown_q [SLOT_COUNT];
	logic                pending_q   [SLOT_COUNT];
	logic [OVR_W-1:0]    cur_ovr_q   [SLOT_COUNT];
	logic [OVC_W-1:0]    ovr_cnt_q   [SLOT_COUNT];
	logic [RESP_W-1:0]   max_resp_q  [SLOT_COUNT];

	// input register and task walk
	logic                busy_s1;
	logic [3:0]          idle_s1;
	logic [3:0]          unav_s1;
	logic [TASK_W-1:0]   task_q;

	// output register
	logic                out_valid_q;
	result_t             out_q;

	logic advance;
	logic last_step;
	logic cfg_wr;
	logic cfg_is_period;
	logic cfg_is_phase;
	logic [TASK_W-1:0] cfg_phase_off;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign advance   = busy_s1 && (!out_valid_q || m_tready);
	assign last_step = advance && (task_q == LAST_TASK);
	assign s_tready  = !busy_s1 || last_step;

	// decode config index
	assign cfg_is_period = (cfg_index < REG_PHASE_BASE);
	assign cfg_is_phase  = (cfg_index >= REG_PHASE_BASE) && (cfg_index < REG_END);
	assign cfg_phase_off = TASK_W'(cfg_index - REG_PHASE_BASE);

	// per-task update for the task under the walk
	logic                cur_idle;
	logic                cur_unav;
	logic [PERIOD_W-1:0] cd_dec;
	logic                fin;
	logic [OVR_W:0]      ovr_inc;
	logic [PERIOD_W+OVR_W:0] prod_full;
	logic [RESP_W-1:0]   prod;
	logic [RESP_W-1:0]   cd_ext;
	logic [RESP_W-1:0]   resp;
	logic [RESP_W-1:0]   max_n;
	logic [PERIOD_W-1:0] cd_n;
	logic                pend_n;
	logic [OVR_W-1:0]    ovr_n;
	logic [OVC_W-1:0]    ovc_n;
	logic                rel;
	logic                ovr_hit;

	always_comb begin
		cur_idle  = idle_s1[task_q];
		cur_unav  = unav_s1[task_q];
		cd_dec    = countdown_q[task_q] - PERIOD_W'(1);
		fin       = pending_q[task_q] && cur_idle && !cur_unav;
		ovr_inc   = {1'b0, cur_ovr_q[task_q]} + (OVR_W+1)'(1);
		prod_full = period_q[task_q] * ovr_inc;
		prod      = prod_full[RESP_W-1:0];
		cd_ext    = RESP_W'(cd_dec);
		resp      = '0;
		max_n     = max_resp_q[task_q];
		cd_n      = cd_dec;
		pend_n    = pending_q[task_q];
		ovr_n     = cur_ovr_q[task_q];
		ovc_n     = ovr_cnt_q[task_q];
		rel       = 1'b0;
		ovr_hit   = 1'b0;
		// finished job: record response, restart after task 0 period
		if (fin) begin
			resp   = (prod >= cd_ext) ? (prod - cd_ext) : '0;
			pend_n = 1'b0;
			ovr_n  = '0;
			cd_n   = period_q[0];
			if (resp > max_n) begin
				max_n = resp;
			end
		end
		if (cur_unav) begin
			cd_n = period_q[0];
		end
		// countdown expired: release or count an overrun
		if (cd_n == '0) begin
			pend_n = 1'b1;
			cd_n   = period_q[task_q];
			if (cur_idle) begin
				rel = 1'b1;
			end else begin
				ovr_hit = 1'b1;
				if (ovc_n != OVC_MAX) begin
					ovc_n = ovc_n + OVC_W'(1);
				end
				if (ovr_n != OVR_MAX) begin
					ovr_n = ovr_n + OVR_W'(1);
				end
			end
		end
	end

	// state and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				period_q[i]    <= PERIOD_RESET;
				countdown_q[i] <= PHASE_RESET;
				pending_q[i]   <= 1'b0;
				cur_ovr_q[i]   <= '0;
				ovr_cnt_q[i]   <= '0;
				max_resp_q[i]  <= '0;
			end
		end else begin
			if (cfg_wr && cfg_is_period) begin
				period_q[cfg_index[TASK_W-1:0]] <= cfg_data;
			end
			if (cfg_wr && cfg_is_phase) begin
				countdown_q[cfg_phase_off] <= cfg_data;
			end else if (advance) begin
				countdown_q[task_q] <= cd_n;
			end
			if (advance) begin
				pending_q[task_q]  <= pend_n;
				cur_ovr_q[task_q]  <= ovr_n;
				ovr_cnt_q[task_q]  <= ovc_n;
				max_resp_q[task_q] <= max_n;
			end
		end
	end

	// input register and task walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			task_q  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				busy_s1 <= 1'b1;
			end else if (last_step) begin
				busy_s1 <= 1'b0;
			end
			if (last_step) begin
				task_q <= '0;
			end else if (advance) begin
				task_q <= task_q + TASK_W'(1);
			end
		end
	end

	// hold tick masks
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			idle_s1 <= s_tdata[3:0];
			unav_s1 <= s_tdata[7:4];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.task_index     <= task_q;
			out_q.job_finished   <= fin;
			out_q.response_ticks <= resp;
			out_q.release_now    <= rel;
			out_q.overrun_now    <= ovr_hit;
			out_q.overrun_total  <= ovc_n;
			out_q.worst_response <= max_n;
			out_q.last_of_tick   <= (task_q == LAST_TASK);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.task_index;
	assign m_tlast  = out_q.last_of_tick;
	assign m_tdata  = {5'b0, out_q.worst_response, out_q.overrun_total,
		out_q.overrun_now, out_q.release_now, out_q.response_ticks, out_q.job_finished};

endmodule

`default_nettype wire

>>> rtl/core/prom_checker.sv
// Port-level checks for the periodic release overrun monitor, and the bind
// that attaches them to the top level. Uses prom_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prom_checker
	import prom_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [TASK_W-1:0]     m_tuser,
	input wire logic                  m_tlast
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result beat changed while stalled");

	// tlast marks the final task
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == LAST_TASK)))
		else $error("tlast does not match task index");

	// no response without a finished job
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[24:1] == '0))
		else $error("response reported without finished job");

	// worst response covers this response
	a_worst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[66:43] >= m_tdata[24:1]))
		else $error("worst response below current response");

	// release and overrun exclude each other
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[25] && m_tdata[26]))
		else $error("release and overrun in one beat");

endmodule

bind periodic_release_overrun_monitor prom_checker u_prom_checker (.*);

`default_nettype wire

>>> dv/periodic_release_overrun_monitor_test.sv
// Self-checking bench for the periodic release overrun monitor.
// Drives tick beats and register writes, predicts every per-task result beat.
// Depends on prom_pkg and periodic_release_overrun_monitor.
`timescale 1ns / 1ps

module periodic_release_overrun_monitor_test;
	import prom_pkg::*;

	localparam int unsigned STALL_LIMIT   = 3000;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned RANDOM_PHASES = 5;
	localparam int unsigned PHASE_TICKS   = 32;
	localparam int unsigned SAT_TICKS     = 260;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = '1;
	localparam logic [PERIOD_W-1:0]  PERIOD_TOP    = '1;

	typedef struct {
		result_t     beat;
		int unsigned tick;
	} expected_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;

	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [TASK_W-1:0]     m_tuser;
	logic                  m_tlast;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PERIOD_W-1:0]  cfg_data = '0;

	// mirrored task state
	logic [PERIOD_W-1:0] task_period [SLOT_COUNT];
	logic [PERIOD_W-1:0] task_phase  [SLOT_COUNT];
	logic [PERIOD_W-1:0] countdown   [SLOT_COUNT];
	logic                job_open    [SLOT_COUNT];
	logic [OVR_W-1:0]    run_overruns[SLOT_COUNT];
	logic [OVC_W-1:0]    overrun_tally[SLOT_COUNT];
	logic [RESP_W-1:0]   worst_seen  [SLOT_COUNT];

	logic [IN_DATA_W-1:0] tick_backlog[$];
	expected_beat_t       expected_beats[$];

	int unsigned ticks_queued = 0;
	int unsigned ticks_taken = 0;
	int unsigned beats_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned finishes = 0;
	int unsigned releases = 0;
	int unsigned overruns = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned sink_stall = 0;
	bit          idling_on = 1'b1;
	bit          drain_hold = 1'b0;
	logic                 drive_valid;
	logic [IN_DATA_W-1:0] drive_data;
	logic                 take_ready;

	periodic_release_overrun_monitor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return 0;
		if (roll < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void reset_schedule();
		for (int t = 0; t < SLOT_COUNT; t++) begin
			task_period[t]   = PERIOD_RESET;
			task_phase[t]    = PHASE_RESET;
			countdown[t]     = PHASE_RESET;
			job_open[t]      = 1'b0;
			run_overruns[t]  = '0;
			overrun_tally[t] = '0;
			worst_seen[t]    = '0;
		end
	endfunction

	// mirror one register write; unknown indexes fall through
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [PERIOD_W-1:0] value);
		logic [TASK_W-1:0] slot;
		if (idx < REG_PHASE_BASE) begin
			slot = TASK_W'(idx - REG_PERIOD_BASE);
			task_period[slot] = value;
		end else if (idx < REG_END) begin
			slot = TASK_W'(idx - REG_PHASE_BASE);
			task_phase[slot] = value;
			countdown[slot]  = value;
		end
	endfunction

	// walk the tasks of one tick and queue the beats they produce
	function automatic void advance_tasks(input logic [3:0] idle, input logic [3:0] unavail);
		expected_beat_t    e;
		logic [RESP_W-1:0] product;
		logic [RESP_W-1:0] resp;
		for (int t = 0; t < TASK_COUNT; t++) begin
			e.beat = '0;
			e.tick = ticks_taken;
			resp = '0;
			countdown[t] = countdown[t] - 1'b1;
			if (job_open[t] && idle[t] && !unavail[t]) begin
				product = RESP_W'(task_period[t]) * (RESP_W'(run_overruns[t]) + 1'b1);
				resp = (product >= RESP_W'(countdown[t])) ?
					product - RESP_W'(countdown[t]) : '0;
				e.beat.job_finished = 1'b1;
				job_open[t] = 1'b0;
				if (resp > worst_seen[t])
					worst_seen[t] = resp;
				run_overruns[t] = '0;
				countdown[t] = task_period[0];
				finishes++;
			end
			if (unavail[t])
				countdown[t] = task_period[0];
			if (countdown[t] == '0) begin
				job_open[t] = 1'b1;
				countdown[t] = task_period[t];
				if (idle[t]) begin
					e.beat.release_now = 1'b1;
					releases++;
				end else begin
					e.beat.overrun_now = 1'b1;
					overruns++;
					if (overrun_tally[t] != OVC_MAX)
						overrun_tally[t]++;
					if (run_overruns[t] != OVR_MAX)
						run_overruns[t]++;
				end
			end
			e.beat.task_index     = TASK_W'(t);
			e.beat.response_ticks = resp;
			e.beat.overrun_total  = overrun_tally[t];
			e.beat.worst_response = worst_seen[t];
			e.beat.last_of_tick   = (t == TASK_COUNT - 1);
			expected_beats.push_back(e);
		end
	endfunction

	function automatic void flag_field(input string field, input expected_beat_t e,
			input longint unsigned want, input longint unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("tick %0d task %0d %s: expected 0x%0h, got 0x%0h",
					e.tick, e.beat.task_index, field, want, got);
		end
	endfunction

	// compare one result beat against the oldest prediction
	function automatic void check_beat();
		expected_beat_t e;
		result_t        got;
		got.task_index     = m_tuser;
		got.job_finished   = m_tdata[0];
		got.response_ticks = m_tdata[24:1];
		got.release_now    = m_tdata[25];
		got.overrun_now    = m_tdata[26];
		got.overrun_total  = m_tdata[42:27];
		got.worst_response = m_tdata[66:43];
		got.last_of_tick   = m_tlast;
		beats_seen++;
		if (expected_beats.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result beat for task %0d with nothing outstanding", got.task_index);
			return;
		end
		e = expected_beats.pop_front();
		flag_field("task_index", e, e.beat.task_index, got.task_index);
		flag_field("job_finished", e, e.beat.job_finished, got.job_finished);
		flag_field("response_ticks", e, e.beat.response_ticks, got.response_ticks);
		flag_field("release_now", e, e.beat.release_now, got.release_now);
		flag_field("overrun_now", e, e.beat.overrun_now, got.overrun_now);
		flag_field("overrun_total", e, e.beat.overrun_total, got.overrun_total);
		flag_field("worst_response", e, e.beat.worst_response, got.worst_response);
		flag_field("last_of_tick", e, e.beat.last_of_tick, got.last_of_tick);
	endfunction

	// tick driver: present backlog beats, predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			drive_valid = s_tvalid;
			drive_data  = s_tdata;
			if (s_tvalid && s_tready) begin
				advance_tasks(s_tdata[3:0], s_tdata[7:4]);
				ticks_taken++;
				drive_valid = 1'b0;
				send_gap = idling_on ? pick_gap() : 0;
				if (idling_on && $urandom_range(0, 39) == 0)
					drain_hold = 1'b1;
			end
			if (drain_hold && expected_beats.size() == 0)
				drain_hold = 1'b0;
			if (!drive_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (!drain_hold && tick_backlog.size() > 0) begin
					drive_data  = tick_backlog.pop_front();
					drive_valid = 1'b1;
				end
			end
			s_tvalid <= drive_valid;
			s_tdata  <= drive_data;
		end
	end

	// result sink: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_beat();
			take_ready = 1'b1;
			if (sink_stall > 0) begin
				sink_stall--;
				take_ready = 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				sink_stall = pick_gap();
				if (sink_stall > 0) begin
					sink_stall--;
					take_ready = 1'b0;
				end
			end
			m_tready <= take_ready;
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: %0d cycles without a beat, %0d results outstanding",
					quiet_cycles, expected_beats.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_reg(idx, value);
		reg_writes++;
	endtask

	task automatic queue_tick(input logic [3:0] idle, input logic [3:0] unavail);
		tick_backlog.push_back({unavail, idle});
		ticks_queued++;
	endtask

	// hold until every tick is taken and every result is back
	task automatic wait_drained();
		do
			@(posedge clk);
		while (ticks_taken != ticks_queued || expected_beats.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 9))
			0: return PERIOD_TOP;
			1: return PERIOD_W'($urandom_range(1, 65535));
			default: return PERIOD_W'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [PERIOD_W-1:0] pick_phase();
		case ($urandom_range(0, 9))
			0: return PERIOD_TOP;
			1: return PERIOD_W'($urandom_range(1, 300));
			default: return PERIOD_W'($urandom_range(1, 5));
		endcase
	endfunction

	task automatic load_random_schedule();
		for (int t = 0; t < SLOT_COUNT; t++)
			write_reg(REG_PERIOD_BASE + CFG_IDX_W'(t), pick_period());
		for (int t = 0; t < SLOT_COUNT; t++)
			write_reg(REG_PHASE_BASE + CFG_IDX_W'(t), pick_phase());
	endtask

	// mostly random idle masks with rare unavailable flags, some pure noise
	task automatic queue_random_ticks(input int unsigned count);
		logic [3:0] idle;
		logic [3:0] unavail;
		for (int unsigned i = 0; i < count; i++) begin
			idle = 4'($urandom_range(0, 15));
			unavail = '0;
			if ($urandom_range(0, 9) == 0) begin
				unavail = 4'($urandom_range(0, 15));
			end else begin
				for (int b = 0; b < 4; b++)
					unavail[b] = ($urandom_range(0, 7) == 0);
			end
			queue_tick(idle, unavail);
		end
	endtask

	initial begin
		int unsigned saturated;
		reset_schedule();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset schedule: mask extremes, overrun then finish, unavailable restarts
		queue_tick(4'h0, 4'h0);
		queue_tick(4'hF, 4'h0);
		queue_tick(4'hF, 4'hF);
		queue_tick(4'h0, 4'hF);
		queue_tick(4'h5, 4'hA);
		queue_tick(4'hA, 4'h5);
		wait_drained();

		// zero phase wraps the countdown; unavailable restart yields a clipped response
		write_reg(REG_PERIOD_BASE + CFG_IDX_W'(0), PERIOD_TOP);
		write_reg(REG_PERIOD_BASE + CFG_IDX_W'(1), 16'd1);
		write_reg(REG_PERIOD_BASE + CFG_IDX_W'(2), 16'd2);
		write_reg(REG_PERIOD_BASE + CFG_IDX_W'(3), 16'd3);
		write_reg(REG_PHASE_BASE + CFG_IDX_W'(0), 16'd1);
		write_reg(REG_PHASE_BASE + CFG_IDX_W'(1), 16'd1);
		write_reg(REG_PHASE_BASE + CFG_IDX_W'(2), 16'd0);
		write_reg(REG_PHASE_BASE + CFG_IDX_W'(3), PERIOD_TOP);
		write_reg(REG_END, 16'h5A5A);
		write_reg(REG_INDEX_TOP, PERIOD_TOP);
		queue_tick(4'h0, 4'h0);
		queue_tick(4'h0, 4'h2);
		queue_tick(4'h2, 4'h0);
		queue_tick(4'hF, 4'h0);
		queue_tick(4'h0, 4'h0);
		queue_tick(4'hF, 4'hF);
		queue_tick(4'hC, 4'h3);
		wait_drained();

		// zero period reloads a countdown of zero
		write_reg(REG_PERIOD_BASE + CFG_IDX_W'(0), 16'd1);
		write_reg(REG_PERIOD_BASE + CFG_IDX_W'(1), 16'd0);
		write_reg(REG_PERIOD_BASE + CFG_IDX_W'(2), PERIOD_TOP);
		write_reg(REG_PERIOD_BASE + CFG_IDX_W'(3), 16'd1);
		write_reg(REG_PHASE_BASE + CFG_IDX_W'(0), 16'd1);
		write_reg(REG_PHASE_BASE + CFG_IDX_W'(1), 16'd1);
		write_reg(REG_PHASE_BASE + CFG_IDX_W'(2), 16'd2);
		write_reg(REG_PHASE_BASE + CFG_IDX_W'(3), 16'd2);
		queue_tick(4'h0, 4'h0);
		queue_tick(4'h0, 4'h0);
		queue_tick(4'hF, 4'h0);
		queue_tick(4'h0, 4'h0);
		queue_tick(4'hF, 4'h0);
		queue_tick(4'h9, 4'h6);
		wait_drained();

		// random schedules; one phase runs without gaps on either side
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			load_random_schedule();
			idling_on = (p != 2);
			queue_random_ticks(PHASE_TICKS);
			wait_drained();
		end
		idling_on = 1'b1;

		// busy workers on period one: overrun every tick until the per-job count saturates
		for (int t = 0; t < SLOT_COUNT; t++) begin
			write_reg(REG_PERIOD_BASE + CFG_IDX_W'(t), 16'd1);
			write_reg(REG_PHASE_BASE + CFG_IDX_W'(t), 16'd1);
		end
		idling_on = 1'b0;
		for (int unsigned i = 0; i < SAT_TICKS; i++)
			queue_tick(4'h0, 4'h0);
		wait_drained();
		idling_on = 1'b1;

		// finish with saturated overruns on the largest period: widest product
		for (int t = 0; t < SLOT_COUNT; t++)
			write_reg(REG_PERIOD_BASE + CFG_IDX_W'(t), PERIOD_TOP);
		queue_tick(4'hF, 4'h0);
		queue_tick(4'h0, 4'h0);
		wait_drained();

		load_random_schedule();
		queue_random_ticks(PHASE_TICKS / 2);
		wait_drained();

		if (expected_beats.size() != 0) begin
			mismatches += expected_beats.size();
			$display("%0d predicted results never arrived", expected_beats.size());
		end
		saturated = 0;
		for (int t = 0; t < SLOT_COUNT; t++)
			if (overrun_tally[t] == OVC_MAX)
				saturated++;
		$display("ran %0d ticks, %0d result beats, %0d register writes",
			ticks_taken, beats_seen, reg_writes);
		$display("saw %0d finishes, %0d releases, %0d overruns; %0d tasks hit the overrun cap",
			finishes, releases, overruns, saturated);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/prom_pkg.sv
rtl/core/periodic_release_overrun_monitor.sv
rtl/core/prom_checker.sv
dv/periodic_release_overrun_monitor_test.sv
